// ----- rtl/otve_pkg.sv -----
// Package for the ordered tag value extractor.
// Sizes, character codes, op and phase types, tag store port structs.
// No dependencies.
package otve_pkg;

  localparam int MAX_TAGS = 16;
  localparam int TAG_LEN  = 16;

  localparam int IDX_W  = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int CUR_W  = $clog2(MAX_TAGS + 1);
  localparam int POS_W  = $clog2(TAG_LEN + 1);
  localparam int COL_W  = (TAG_LEN > 1) ? $clog2(TAG_LEN) : 1;
  localparam int SKIP_W = $clog2(TAG_LEN + 3);
  localparam int OIDX_W = 4;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_NUL = 8'h00;

  // closing tag is "</" + tag + ">", the '<' already consumed
  localparam int CLOSE_EXTRA = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_START  = 2'd1,
    OP_TEXT   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEARCH,
    PH_CHECK,
    PH_CAPTURE,
    PH_SKIP
  } phase_t;

  typedef logic [TAG_LEN-1:0][7:0] tag_row_t;

  typedef struct packed {
    logic             byte_we;
    logic             len_we;
    logic [IDX_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       data;
    logic [POS_W-1:0] len;
  } tag_wr_t;

  typedef struct packed {
    tag_row_t         row_a;
    logic [POS_W-1:0] len_a;
    logic [7:0]       byte0_b;
    logic [POS_W-1:0] len_b;
  } tag_rd_t;

endpackage

// ----- rtl/otve_if.sv -----
// Valid/ready channel interfaces for the extractor's input and result words.
// No dependencies; its widths are written out and not taken from otve_pkg.
interface otve_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_req;
  logic       tag_end;

  modport source (output valid, output op, output byte_req, output tag_end, input ready);
  modport sink   (input valid, input op, input byte_req, input tag_end, output ready);
endinterface

interface otve_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] tag_index;
  logic [7:0] value_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output tag_index, output value_byte, output has_byte,
                  output last, input ready);
  modport sink   (input valid, input tag_index, input value_byte, input has_byte,
                  input last, output ready);
endinterface

// ----- rtl/otve_tag_store.sv -----
// Tag store: one row of tag characters and one length per tag, synchronous memories.
// Port A reads a full row and length, port B the first character and length.
// Depends on otve_pkg.
module otve_tag_store import otve_pkg::*; (
  input  logic             clk,
  input  tag_wr_t          wr,
  input  logic [IDX_W-1:0] addr_a,
  input  logic [IDX_W-1:0] addr_b,
  output tag_rd_t          rd
);

  tag_row_t         tag_mem [MAX_TAGS];
  logic [POS_W-1:0] len_mem [MAX_TAGS];

  tag_row_t         row_a_r;
  logic             fwd_a_r;
  logic [COL_W-1:0] fwd_col_r;
  logic [7:0]       fwd_data_r;
  logic [POS_W-1:0] len_a_r;
  logic [7:0]       byte0_b_r;
  logic [POS_W-1:0] len_b_r;
  tag_row_t         row_a_fwd;

  // write-first: a word written at the same edge is forwarded to the read data
  always_ff @(posedge clk) begin
    if (wr.byte_we) begin
      tag_mem[wr.row][wr.col] <= wr.data;
    end
    if (wr.len_we) begin
      len_mem[wr.row] <= wr.len;
    end

    row_a_r    <= tag_mem[addr_a];
    fwd_a_r    <= wr.byte_we && wr.row == addr_a;
    fwd_col_r  <= wr.col;
    fwd_data_r <= wr.data;
    len_a_r <= (wr.len_we && wr.row == addr_a) ? wr.len : len_mem[addr_a];

    byte0_b_r <= (wr.byte_we && wr.row == addr_b && wr.col == '0) ?
                 wr.data : tag_mem[addr_b][0];
    len_b_r   <= (wr.len_we && wr.row == addr_b) ? wr.len : len_mem[addr_b];
  end

  // patch the character written at the read edge into the row
  always_comb begin
    row_a_fwd = row_a_r;
    if (fwd_a_r) begin
      row_a_fwd[fwd_col_r] = fwd_data_r;
    end
  end

  assign rd.row_a   = row_a_fwd;
  assign rd.len_a   = len_a_r;
  assign rd.byte0_b = byte0_b_r;
  assign rd.len_b   = len_b_r;

endmodule

// ----- rtl/ordered_tag_value_extractor.sv -----
// Ordered tag value extractor, top level. Latency: a result word is valid the cycle
// after the text byte that causes it is accepted. Throughput: up to one word per cycle
// while the output is not stalled, set by the window compare against the current
// tag's registered row. Reset (rst_n, synchronous, active low) clears phase, counters
// and the output valid flag; the tag store has no valid bits and needs no clearing pass.
// Depends on otve_pkg, otve_if, otve_tag_store.
module ordered_tag_value_extractor import otve_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  otve_in_if.sink     in_ch,
  otve_out_if.source  out_ch
);

  phase_t            phase_r, phase_nxt;
  logic [CUR_W-1:0]  cur_r, cur_nxt;
  logic [CUR_W-1:0]  total_r, total_nxt;
  logic [POS_W-1:0]  app_pos_r, app_pos_nxt;
  logic [POS_W-1:0]  fill_r, fill_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [7:0]        win_r [TAG_LEN];
  logic [7:0]        win_new [TAG_LEN];

  logic              out_valid_r, out_valid_nxt;
  logic [OIDX_W-1:0] out_tag_r;
  logic [7:0]        out_byte_r;
  logic              out_has_r;
  logic              out_last_r;

  logic              in_ready, fire, emit, win_shift;
  logic [7:0]        o_byte;
  logic              o_has, o_last;
  logic [7:0]        b;
  logic [POS_W-1:0]  fill_sat;
  logic [TAG_LEN:0]  hit_vec;
  logic              hit_a;
  logic [CUR_W-1:0]  cur_inc;
  logic [SKIP_W-1:0] skip_dec;

  tag_wr_t           wr;
  tag_rd_t           rd;

  otve_tag_store u_store (
    .clk    (clk),
    .wr     (wr),
    .addr_a (cur_nxt[IDX_W-1:0]),
    .addr_b (cur_inc[IDX_W-1:0]),
    .rd     (rd)
  );

  assign b        = in_ch.byte_req;
  assign in_ready = !out_valid_r || out_ch.ready;
  assign fire     = in_ch.valid && in_ready;
  assign cur_inc  = cur_nxt + CUR_W'(1);
  assign fill_sat = (fill_r < POS_W'(TAG_LEN)) ? fill_r + POS_W'(1) : fill_r;
  assign skip_dec = (skip_r != '0) ? skip_r - SKIP_W'(1) : skip_r;

  always_comb begin
    for (int k = 0; k < TAG_LEN - 1; k++) begin
      win_new[k] = win_r[k+1];
    end
    win_new[TAG_LEN-1] = b;
  end

  // hit_vec[l]: the newest l window bytes equal the first l tag characters
  always_comb begin
    logic ok;
    hit_vec[0] = 1'b0;
    for (int l = 1; l <= TAG_LEN; l++) begin
      ok = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (win_new[TAG_LEN-l+k] != rd.row_a[k]) begin
          ok = 1'b0;
        end
      end
      hit_vec[l] = ok;
    end
  end

  assign hit_a = (fill_sat >= rd.len_a) && hit_vec[rd.len_a];

  always_comb begin
    phase_nxt   = phase_r;
    cur_nxt     = cur_r;
    total_nxt   = total_r;
    app_pos_nxt = app_pos_r;
    fill_nxt    = fill_r;
    skip_nxt    = skip_r;
    emit        = 1'b0;
    o_byte      = CH_NUL;
    o_has       = 1'b0;
    o_last      = 1'b0;
    win_shift   = 1'b0;
    wr          = '0;
    wr.row      = total_r[IDX_W-1:0];
    wr.col      = app_pos_r[COL_W-1:0];
    wr.data     = b;

    if (fire) begin
      case (in_ch.op)
        OP_APPEND: begin
          if (total_r < CUR_W'(MAX_TAGS)) begin
            if (app_pos_r < POS_W'(TAG_LEN)) begin
              wr.byte_we  = 1'b1;
              app_pos_nxt = app_pos_r + POS_W'(1);
            end
            if (in_ch.tag_end) begin
              wr.len_we   = 1'b1;
              wr.len      = app_pos_nxt;
              total_nxt   = total_r + CUR_W'(1);
              app_pos_nxt = '0;
            end
          end
        end
        OP_START: begin
          cur_nxt   = '0;
          skip_nxt  = '0;
          fill_nxt  = '0;
          phase_nxt = (total_r == '0) ? PH_IDLE : PH_SEARCH;
        end
        OP_TEXT: begin
          if (phase_r != PH_IDLE) begin
            if (b == CH_NUL) begin
              phase_nxt = PH_IDLE;
              if (phase_r == PH_CAPTURE) begin
                emit   = 1'b1;
                o_last = 1'b1;
              end
            end else begin
              case (phase_r)
                PH_SEARCH: begin
                  win_shift = 1'b1;
                  fill_nxt  = fill_sat;
                  if (hit_a) begin
                    phase_nxt = PH_CHECK;
                  end
                end
                PH_CHECK: begin
                  if (b == CH_GT) begin
                    phase_nxt = PH_CAPTURE;
                  end else begin
                    cur_nxt = cur_r + CUR_W'(1);
                    if (cur_nxt >= total_r) begin
                      phase_nxt = PH_IDLE;
                    end else begin
                      // this byte opens the next tag's search; only a one-char tag can hit
                      win_shift = 1'b1;
                      fill_nxt  = POS_W'(1);
                      phase_nxt = (rd.len_b == POS_W'(1) && b == rd.byte0_b) ?
                                  PH_CHECK : PH_SEARCH;
                    end
                  end
                end
                PH_CAPTURE: begin
                  emit = 1'b1;
                  if (b == CH_LT) begin
                    o_last   = 1'b1;
                    skip_nxt = SKIP_W'(rd.len_a) + SKIP_W'(CLOSE_EXTRA);
                    cur_nxt  = cur_r + CUR_W'(1);
                    fill_nxt = '0;
                    phase_nxt = (cur_nxt >= total_r) ? PH_IDLE : PH_SKIP;
                  end else begin
                    o_byte = b;
                    o_has  = 1'b1;
                  end
                end
                PH_SKIP: begin
                  skip_nxt = skip_dec;
                  if (skip_dec == '0) begin
                    phase_nxt = PH_SEARCH;
                    fill_nxt  = '0;
                  end
                end
                default: begin
                  phase_nxt = PH_IDLE;
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cur_r       <= '0;
      total_r     <= '0;
      app_pos_r   <= '0;
      fill_r      <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cur_r       <= cur_nxt;
      total_r     <= total_nxt;
      app_pos_r   <= app_pos_nxt;
      fill_r      <= fill_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_shift) begin
      win_r <= win_new;
    end
    if (emit) begin
      out_tag_r  <= OIDX_W'(cur_r);
      out_byte_r <= o_byte;
      out_has_r  <= o_has;
      out_last_r <= o_last;
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.tag_index  = out_tag_r;
  assign out_ch.value_byte = out_byte_r;
  assign out_ch.has_byte   = out_has_r;
  assign out_ch.last       = out_last_r;

endmodule

// ----- rtl/otve_checker.sv -----
// Port-level checker for ordered_tag_value_extractor, attached by bind.
// Depends on otve_pkg.
module otve_checker import otve_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_tag_index,
  input logic [7:0] out_value_byte,
  input logic       out_has_byte,
  input logic       out_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag_index)
      && $stable(out_value_byte) && $stable(out_has_byte) && $stable(out_last))
    else $error("result word changed while stalled");

  // end marker carries no character
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && out_value_byte == 8'h00)
    else $error("malformed end marker");

  a_value_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> !out_last)
    else $error("value word flagged last");

  // a new result word only follows an accepted text word
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_op == OP_TEXT))
    else $error("result word without a text word");

endmodule

bind ordered_tag_value_extractor otve_checker u_otve_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_tag_index  (out_ch.tag_index),
  .out_value_byte (out_ch.value_byte),
  .out_has_byte   (out_ch.has_byte),
  .out_last       (out_ch.last)
);
